// ----- hdl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared sizes, command codes, record layout and control structs.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH      = 256;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int MODE_W     = 2;
  localparam int IN_DATA_W  = KEY_W + VAL_W;
  localparam int OUT_DATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  // IEEE-754 single precision pattern for -1.0, returned on a miss.
  localparam logic [VAL_W-1:0] MISS_WORD = 32'hBF80_0000;

  typedef struct packed {
    logic [KEY_W-1:0] id;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] found_value;
    logic             overflow;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

// ----- hdl/skt_table.sv -----
// ----------------------------------------------------------------------------
// Sorted key table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skt_table (
  input  logic                     clk,
  input  skt_pkg::tbl_wr_t         wr,
  input  logic [skt_pkg::IDX_W-1:0] rd_addr,
  output skt_pkg::entry_t          rd_data
);

  skt_pkg::entry_t mem [skt_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/skt_seq.sv -----
// ----------------------------------------------------------------------------
// Sorted key table sequencer
// Runs the binary search (lookup and insert position) and the record shift
// over one table read port, around a single shared key comparator.
// ----------------------------------------------------------------------------
module skt_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           ready,
  input  logic [skt_pkg::MODE_W-1:0]     mode,
  input  logic [skt_pkg::KEY_W-1:0]      key,
  input  logic [skt_pkg::VAL_W-1:0]      base_value,
  input  logic                           out_free,
  output logic                           res_valid,
  output skt_pkg::result_t               res,
  output skt_pkg::tbl_wr_t               wr,
  output logic [skt_pkg::IDX_W-1:0]      rd_addr,
  input  skt_pkg::entry_t                rd_data
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PROBE    = 3'd1;
  localparam logic [2:0] S_CMP      = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0]                   state;
  logic [skt_pkg::MODE_W-1:0]   mode_r;
  logic [skt_pkg::KEY_W-1:0]    key_r;
  logic [skt_pkg::VAL_W-1:0]    value_r;
  logic [skt_pkg::CNT_W-1:0]    count;
  logic [skt_pkg::CNT_W-1:0]    lo;
  logic [skt_pkg::CNT_W-1:0]    hi;
  logic [skt_pkg::CNT_W-1:0]    ptr;
  logic [skt_pkg::IDX_W-1:0]    mid;
  logic                         hit;
  logic [skt_pkg::VAL_W-1:0]    found_value;
  logic                         overflow;

  logic [skt_pkg::CNT_W:0]      mid_sum;
  logic [skt_pkg::IDX_W-1:0]    mid_c;
  logic [skt_pkg::CNT_W-1:0]    ptr_dec;
  logic [skt_pkg::CNT_W-1:0]    mid_inc;
  logic                         probe_gt;
  logic                         probe_eq;

  // Search window is [lo, hi); the midpoint matches floor((lo + (hi - 1)) / 2).
  assign mid_sum = {1'b0, lo} + {1'b0, hi} - {{skt_pkg::CNT_W{1'b0}}, 1'b1};
  assign mid_c   = mid_sum[skt_pkg::IDX_W:1];
  assign ptr_dec = ptr - {{(skt_pkg::CNT_W-1){1'b0}}, 1'b1};
  assign mid_inc = {1'b0, mid} + {{(skt_pkg::CNT_W-1){1'b0}}, 1'b1};

  // The one comparator shared by both searches.
  assign probe_gt = rd_data.id > key_r;
  assign probe_eq = rd_data.id == key_r;

  assign ready     = state == S_IDLE;
  assign res_valid = state == S_DONE;
  assign res       = '{hit: hit, found_value: found_value, overflow: overflow, count: count};
  assign rd_addr   = (state == S_SHIFT_RD) ? ptr_dec[skt_pkg::IDX_W-1:0] : mid_c;

  always_comb begin
    wr = '0;
    if (state == S_SHIFT_WR) begin
      wr.en   = 1'b1;
      wr.addr = ptr[skt_pkg::IDX_W-1:0];
      wr.data = rd_data;
    end else if (state == S_SHIFT_RD && ptr == lo) begin
      wr.en         = 1'b1;
      wr.addr       = lo[skt_pkg::IDX_W-1:0];
      wr.data.id    = key_r;
      wr.data.value = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_r      <= mode;
            key_r       <= key;
            value_r     <= base_value;
            lo          <= '0;
            hi          <= count;
            hit         <= 1'b0;
            found_value <= '0;
            overflow    <= 1'b0;
            case (mode)
              skt_pkg::MODE_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              skt_pkg::MODE_INSERT: begin
                if (count == skt_pkg::CNT_W'(skt_pkg::DEPTH)) begin
                  overflow <= 1'b1;
                  state    <= S_DONE;
                end else begin
                  state <= S_PROBE;
                end
              end
              skt_pkg::MODE_LOOKUP: begin
                state <= S_PROBE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_PROBE: begin
          if (lo < hi) begin
            mid   <= mid_c;
            state <= S_CMP;
          end else if (mode_r == skt_pkg::MODE_LOOKUP) begin
            found_value <= skt_pkg::MISS_WORD;
            state       <= S_DONE;
          end else begin
            ptr   <= count;
            state <= S_SHIFT_RD;
          end
        end
        S_CMP: begin
          state <= S_PROBE;
          if (mode_r == skt_pkg::MODE_LOOKUP && probe_eq) begin
            hit         <= 1'b1;
            found_value <= rd_data.value;
            state       <= S_DONE;
          end else if (probe_gt) begin
            hi <= skt_pkg::CNT_W'(mid);
          end else begin
            // An insert lands after every equal id.
            lo <= mid_inc;
          end
        end
        S_SHIFT_RD: begin
          if (ptr > lo) begin
            state <= S_SHIFT_WR;
          end else begin
            count <= count + {{(skt_pkg::CNT_W-1){1'b0}}, 1'b1};
            state <= S_DONE;
          end
        end
        S_SHIFT_WR: begin
          ptr   <= ptr_dec;
          state <= S_SHIFT_RD;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/sorted_key_table_binary_search.sv -----
// ----------------------------------------------------------------------------
// Sorted key table with binary search lookup
// Holds up to 256 (id, value word) records in ascending unsigned id order.
// A clear goes straight to its result. A lookup reads one record per probe of
// the binary search. An insert probes to find its place, then moves each
// record above it up one slot with a read and a write, and writes the new
// record last. The single read port of the table shapes this flow: every
// probe and every moved record is one read.
// One item is worked on at a time; a new item is taken while the previous
// result still waits in the output register.
// ----------------------------------------------------------------------------
module sorted_key_table_binary_search (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [skt_pkg::IN_DATA_W-1:0]     s_tdata,  // key, base_value
  input  logic [skt_pkg::MODE_W-1:0]        s_tuser,  // mode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [skt_pkg::OUT_DATA_W-1:0]    m_tdata,  // found_value, count, zero fill
  output logic [skt_pkg::OUT_USER_W-1:0]    m_tuser   // hit, overflow
);

  logic                          out_free;
  logic                          res_valid;
  skt_pkg::result_t              res;
  skt_pkg::result_t              out_r;
  skt_pkg::tbl_wr_t              wr;
  logic [skt_pkg::IDX_W-1:0]     rd_addr;
  skt_pkg::entry_t               rd_data;

  assign out_free = !m_tvalid || m_tready;

  skt_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .ready      (s_tready),
    .mode       (s_tuser),
    .key        (s_tdata[skt_pkg::KEY_W-1:0]),
    .base_value (s_tdata[skt_pkg::IN_DATA_W-1:skt_pkg::KEY_W]),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res),
    .wr         (wr),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  skt_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_r <= res;
    end
  end

  assign m_tdata = {{(skt_pkg::OUT_DATA_W - skt_pkg::VAL_W - skt_pkg::CNT_W){1'b0}},
                    out_r.count, out_r.found_value};
  assign m_tuser = {out_r.overflow, out_r.hit};

endmodule

// ----- hdl/skt_checker.sv -----
// ----------------------------------------------------------------------------
// Sorted key table port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module skt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [skt_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [skt_pkg::OUT_USER_W-1:0] m_tuser
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // After an input transfer the block is not ready in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again right after a transfer");

  // The record count never exceeds the table size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[skt_pkg::VAL_W +: skt_pkg::CNT_W] <= skt_pkg::CNT_W'(skt_pkg::DEPTH))
    else $error("record count beyond table size");

  // A result is never both a hit and an overflow.
  a_hit_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("hit and overflow both set");

endmodule

bind sorted_key_table_binary_search skt_checker u_skt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- tb/sorted_key_table_binary_search_tb.sv -----
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Sends clear, insert, lookup and unused commands through the input stream
// and holds a behavioral copy of the sorted table to work out the results that
// directed rows do not give. The test opens with a short table of directed
// commands. Random phases follow that use small tables, repeated ids and near
// misses, and fill the table to overflow. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module sorted_key_table_binary_search_tb;
  import skt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int ITEM_TARGET = 1950;
  localparam int CYCLE_LIMIT = 4_000_000;
  // An insert at the front of a nearly full table is the slowest command.
  localparam int DRAIN_CYCLES = 2 * DEPTH + 100;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  word;
    bit                typed;
    logic              hit;
    logic [VAL_W-1:0]  found;
    logic              ovf;
    logic [CNT_W-1:0]  count;
  } cmd_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // key, base_value
  logic [MODE_W-1:0]     s_tuser = MODE_CLEAR;  // mode
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;   // found_value, count, zero fill
  logic [OUT_USER_W-1:0] m_tuser;   // hit, overflow

  sorted_key_table_binary_search dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // Shadow copy of the table.
  logic [KEY_W-1:0] id_tbl [DEPTH];
  logic [VAL_W-1:0] word_tbl [DEPTH];
  int               held = 0;

  result_t pending_results [$];
  int      fail_count = 0;
  int      items_sent = 0;
  int      cycles = 0;
  bit      tx_calm = 1'b0;
  bit      rx_calm = 1'b0;

  cmd_row_t directed_rows [0:20] = '{
    '{MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_WORD, 1'b0, 9'd0},
    '{MODE_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0,     1'b0, 9'd1},
    '{MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0,     1'b0, 9'd2},
    '{MODE_INSERT, 32'h8000_0000, 32'h3F80_0000, 1'b0, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_INSERT, 32'h8000_0000, 32'h4000_0000, 1'b0, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_INSERT, 32'h8000_0000, 32'h4040_0000, 1'b0, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_LOOKUP, 32'h0000_0000, 32'h5555_5555, 1'b0, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_LOOKUP, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_LOOKUP, 32'h8000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_SPARE,  32'h0000_0005, 32'h1234_5678, 1'b0, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_INSERT, 32'h0000_0001, MISS_WORD,     1'b0, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_WORD, 1'b0, 9'd0},
    '{MODE_INSERT, 32'h1234_5678, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0,     1'b0, 9'd0},
    '{MODE_LOOKUP, 32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0, 32'h0,     1'b0, 9'd0}
  };

  // Applies one command to the shadow table and returns the result it makes.
  function automatic result_t table_step(logic [MODE_W-1:0] mode,
                                         logic [KEY_W-1:0] key,
                                         logic [VAL_W-1:0] word);
    result_t r;
    int      pos;
    int      lo;
    int      hi;
    int      mid;
    bit      done;
    r = '0;
    case (mode)
      MODE_CLEAR: begin
        held = 0;
      end
      MODE_INSERT: begin
        if (held >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          // Equal ids keep arrival order, so the new record goes after them.
          pos = 0;
          while (pos < held && id_tbl[pos] <= key) pos++;
          for (int i = held; i > pos; i--) begin
            id_tbl[i]   = id_tbl[i-1];
            word_tbl[i] = word_tbl[i-1];
          end
          id_tbl[pos]   = key;
          word_tbl[pos] = word;
          held++;
        end
      end
      MODE_LOOKUP: begin
        r.found_value = MISS_WORD;
        lo = 0;
        hi = held - 1;
        done = 1'b0;
        while (!done && lo <= hi) begin
          mid = (lo + hi) / 2;
          if (id_tbl[mid] > key) begin
            hi = mid - 1;
          end else if (id_tbl[mid] < key) begin
            lo = mid + 1;
          end else begin
            r.hit = 1'b1;
            r.found_value = word_tbl[mid];
            done = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(held);
    return r;
  endfunction

  // Presents one command and returns once its transfer has taken place.
  task automatic send_item(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                           logic [VAL_W-1:0] word, bit typed, result_t typed_res);
    int      gap;
    result_t exp;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    exp = table_step(mode, key, word);
    pending_results.insert(pending_results.size(), typed ? typed_res : exp);
    s_tvalid <= 1'b1;
    s_tdata  <= {word, key};
    s_tuser  <= mode;
    items_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_cmd(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                          logic [VAL_W-1:0] word);
    send_item(mode, key, word, 1'b0, '0);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(negedge clk);
  endtask

  // Mixes repeated small ids, ids near the top, wide random ids, held ids
  // and their neighbors, which are likely misses.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 4))
      0: k = KEY_W'($urandom_range(0, 7));
      1: k = 32'hFFFF_FFFF - KEY_W'($urandom_range(0, 7));
      2: k = $urandom;
      3: k = (held > 0) ? id_tbl[$urandom_range(0, held - 1)] : $urandom;
      default: begin
        k = (held > 0) ? id_tbl[$urandom_range(0, held - 1)] : $urandom;
        k = $urandom_range(0, 1) ? k + 1 : k - 1;
      end
    endcase
    return k;
  endfunction

  task automatic fill_phase();
    send_cmd(MODE_CLEAR, $urandom, $urandom);
    while (held < DEPTH) begin
      if ($urandom_range(0, 3) == 0) send_cmd(MODE_LOOKUP, pick_key(), $urandom);
      else send_cmd(MODE_INSERT, pick_key(), $urandom);
    end
    // Inserts into the full table are dropped and flagged.
    repeat ($urandom_range(3, 8)) begin
      send_cmd(MODE_INSERT, pick_key(), $urandom);
      send_cmd(MODE_LOOKUP, pick_key(), $urandom);
    end
  endtask

  task automatic mixed_phase();
    int len;
    int pick;
    if ($urandom_range(0, 9) < 7) send_cmd(MODE_CLEAR, $urandom, $urandom);
    len = $urandom_range(5, 40);
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) send_cmd(MODE_INSERT, pick_key(), $urandom);
      else if (pick < 85) send_cmd(MODE_LOOKUP, pick_key(), $urandom);
      else if (pick < 90) send_cmd(MODE_CLEAR, $urandom, $urandom);
      else if (pick < 95) send_cmd(MODE_SPARE, $urandom, $urandom);
      else send_cmd(MODE_INSERT, pick_key(), MISS_WORD);
    end
  endtask

  initial begin : stimulus
    result_t typed_res;
    int      phase;
    int      fills;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_calm = 1'b0;
    foreach (directed_rows[i]) begin
      typed_res = '{directed_rows[i].hit, directed_rows[i].found,
                    directed_rows[i].ovf, directed_rows[i].count};
      send_item(directed_rows[i].mode, directed_rows[i].key, directed_rows[i].word,
                directed_rows[i].typed, typed_res);
    end
    drain();

    phase = 0;
    fills = 0;
    while (items_sent < ITEM_TARGET) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (phase == 1 || $urandom_range(0, 9) < 3) drain();
      if (phase == 0 || (fills < 2 && items_sent > ITEM_TARGET / 2)) begin
        fill_phase();
        fills++;
      end else begin
        mixed_phase();
      end
      phase++;
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : result_sink
    int      stall;
    result_t exp;
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 14);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        fail_count++;
      end else begin
        exp = pending_results.pop_front();
        if (m_tuser[0] !== exp.hit) begin
          $error("hit: expected %0d, actual %0d", exp.hit, m_tuser[0]);
          fail_count++;
        end
        if (m_tdata[VAL_W-1:0] !== exp.found_value) begin
          $error("found_value: expected %08h, actual %08h", exp.found_value,
                 m_tdata[VAL_W-1:0]);
          fail_count++;
        end
        if (m_tuser[1] !== exp.overflow) begin
          $error("overflow: expected %0d, actual %0d", exp.overflow, m_tuser[1]);
          fail_count++;
        end
        if (m_tdata[VAL_W +: CNT_W] !== exp.count) begin
          $error("count: expected %0d, actual %0d", exp.count, m_tdata[VAL_W +: CNT_W]);
          fail_count++;
        end
        if (m_tdata[OUT_DATA_W-1:VAL_W+CNT_W] !== '0) begin
          $error("zero fill: expected 0, actual %0h", m_tdata[OUT_DATA_W-1:VAL_W+CNT_W]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

// ----- files.f -----
hdl/skt_pkg.sv
hdl/skt_table.sv
hdl/skt_seq.sv
hdl/sorted_key_table_binary_search.sv
hdl/skt_checker.sv
tb/sorted_key_table_binary_search_tb.sv
